FILE: rtl/core/kst_pkg.sv
// Shared types and constants of the keyboard scancode tracker.
// Used by kst_modtrack, kst_outbuf and the top level; depends on nothing else.

package kst_pkg;

  localparam int unsigned KeyW = 7;
  localparam int unsigned KeyNum = 128;
  localparam int unsigned CodeW = 8;
  localparam int unsigned ModNum = 8;
  localparam int unsigned ModIdxW = 3;
  localparam int unsigned ModCodesW = 63;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned BufferDepth = 256;

  localparam logic [CfgIdxW-1:0] CfgQueueEnable = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgModifierCodes = 1'd1;

  typedef struct packed {
    logic            valid;
    logic [KeyW-1:0] key;
    logic            press;
  } kst_key_evt_t;

  typedef struct packed {
    logic              busy;
    logic [ModNum-1:0] mask;
  } kst_mod_status_t;

  typedef struct packed {
    logic              stored;
    logic              dropped;
    logic [CodeW-1:0]  slot_index;
    logic [CodeW-1:0]  scancode;
    logic [ModNum-1:0] modifier_mask;
  } kst_result_t;

endpackage

FILE: rtl/core/kst_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Stands alone; width and depth are parameters.

module kst_ram #(
  parameter int unsigned Width = 1,
  parameter int unsigned Depth = 2,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/kst_modtrack.sv
// Key-down map and per-modifier down flags of the scancode tracker.
// Depends on kst_pkg and kst_ram; the map lives in a RAM with valid bits.

module kst_modtrack (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  kst_pkg::kst_key_evt_t               evt_i,
  input  logic [kst_pkg::ModCodesW-1:0]       codes_i,
  input  logic                                reload_i,
  output kst_pkg::kst_mod_status_t            status_o
);

  logic [kst_pkg::KeyNum-1:0]  valid_q;
  logic                        ram_rdata;
  logic [kst_pkg::KeyW-1:0]    rd_addr;
  logic [kst_pkg::ModCodesW:0] codes_ext;
  logic [kst_pkg::CodeW-1:0]   mod_code [kst_pkg::ModNum];
  logic [kst_pkg::ModNum-1:0]  code_ok;
  logic [kst_pkg::ModNum-1:0]  hit;
  logic [kst_pkg::ModNum-1:0]  mask;
  logic [kst_pkg::ModNum-1:0]  mod_down_q, mod_down_d;
  logic                        busy_q;
  logic [kst_pkg::ModIdxW-1:0] cnt_q;
  logic                        rd_pend_q;
  logic [kst_pkg::ModIdxW-1:0] rd_slot_q;
  logic                        rd_vld_q;

  assign codes_ext = {1'b0, codes_i};

  always_comb begin
    for (int i = 0; i < kst_pkg::ModNum; i++) begin
      mod_code[i] = codes_ext[kst_pkg::CodeW*i +: kst_pkg::CodeW];
      code_ok[i]  = (mod_code[i] != '0) && !mod_code[i][kst_pkg::CodeW-1];
      hit[i]      = evt_i.valid && code_ok[i]
                    && (mod_code[i][kst_pkg::KeyW-1:0] == evt_i.key);
      mask[i]     = hit[i] ? evt_i.press : mod_down_q[i];
    end
  end

  always_comb begin
    mod_down_d = mask;
    if (rd_pend_q) begin
      mod_down_d[rd_slot_q] = rd_vld_q && ram_rdata && code_ok[rd_slot_q];
    end
  end

  assign rd_addr = mod_code[cnt_q][kst_pkg::KeyW-1:0];

  kst_ram #(
    .Width(1),
    .Depth(kst_pkg::KeyNum)
  ) u_key_ram (
    .clk_i  (clk_i),
    .we_i   (evt_i.valid),
    .waddr_i(evt_i.key),
    .wdata_i(evt_i.press),
    .raddr_i(rd_addr),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      mod_down_q <= '0;
      busy_q     <= 1'b0;
      cnt_q      <= '0;
      rd_pend_q  <= 1'b0;
      rd_slot_q  <= '0;
      rd_vld_q   <= 1'b0;
    end else begin
      if (evt_i.valid) begin
        valid_q[evt_i.key] <= 1'b1;
      end
      mod_down_q <= mod_down_d;
      if (reload_i) begin
        busy_q    <= 1'b1;
        cnt_q     <= '0;
        rd_pend_q <= 1'b0;
      end else begin
        rd_pend_q <= busy_q;
        rd_slot_q <= cnt_q;
        rd_vld_q  <= valid_q[rd_addr];
        if (busy_q) begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == kst_pkg::ModIdxW'(kst_pkg::ModNum - 1)) begin
            busy_q <= 1'b0;
          end
        end
      end
    end
  end

  assign status_o.busy = busy_q || rd_pend_q;
  assign status_o.mask = mask;

endmodule

FILE: rtl/core/kst_outbuf.sv
// Result register with a skid stage for the output channel.
// Depends on kst_pkg for the result type.

module kst_outbuf (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 load_i,
  input  kst_pkg::kst_result_t res_i,
  input  logic                 out_stall_i,
  output logic                 out_valid_o,
  output kst_pkg::kst_result_t res_o,
  output logic                 skid_full_o
);

  logic                 out_valid_q;
  kst_pkg::kst_result_t out_q;
  logic                 skid_valid_q;
  kst_pkg::kst_result_t skid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || !out_stall_i) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= load_i;
      end
    end else if (load_i) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || !out_stall_i) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (load_i) begin
        out_q <= res_i;
      end
    end else if (load_i) begin
      skid_q <= res_i;
    end
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = out_q;
  assign skid_full_o = skid_valid_q;

endmodule

FILE: rtl/core/keyboard_scancode_tracker_top.sv
// Top level of the keyboard scancode tracker: buffer entry count, result logic.
// Depends on kst_pkg, kst_modtrack and kst_outbuf.

// The block takes one word per clock cycle while the input is not stalled and
// delivers its result word through an output register backed by a skid stage,
// so a stalled output holds back the input only once both are full. A write of
// the modifier codes register starts a reload of the eight modifier flags from
// the key-state RAM, one read per flag; input stays stalled while the reload
// runs. The key map is cleared by reset at once through per-key valid bits, so
// no clearing pass follows reset.

module keyboard_scancode_tracker_top #(
  parameter int unsigned BUFFER_DEPTH = kst_pkg::BufferDepth
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [kst_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [kst_pkg::ModCodesW-1:0]   cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            action_i,
  input  logic [kst_pkg::CodeW-1:0]       scancode_in_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            stored_o,
  output logic                            dropped_o,
  output logic [kst_pkg::CodeW-1:0]       slot_index_o,
  output logic [kst_pkg::CodeW-1:0]       scancode_out_o,
  output logic [kst_pkg::ModNum-1:0]      modifier_mask_o
);

  localparam int unsigned CntW = $clog2(BUFFER_DEPTH + 1);

  logic                          queue_enable_q;
  logic [kst_pkg::ModCodesW-1:0] modifier_codes_q;
  logic [CntW-1:0]               count_q, count_d;
  logic                          accept;
  logic                          full;
  logic                          reload;
  logic                          skid_full;
  kst_pkg::kst_key_evt_t         evt;
  kst_pkg::kst_mod_status_t      mod_status;
  kst_pkg::kst_result_t          res, res_out;

  assign accept = in_valid_i && !in_stall_o;
  assign full   = (count_q >= CntW'(BUFFER_DEPTH));
  assign reload = cfg_we_i && (cfg_idx_i == kst_pkg::CfgModifierCodes);

  assign evt.valid = accept && !action_i;
  assign evt.key   = scancode_in_i[kst_pkg::KeyW-1:0];
  assign evt.press = !scancode_in_i[kst_pkg::CodeW-1];

  always_comb begin
    res     = '0;
    count_d = count_q;
    if (accept) begin
      if (action_i) begin
        count_d = '0;
      end else if (queue_enable_q) begin
        if (full) begin
          res.dropped = 1'b1;
        end else begin
          res.stored        = 1'b1;
          res.slot_index    = kst_pkg::CodeW'(count_q);
          res.scancode      = scancode_in_i;
          res.modifier_mask = mod_status.mask;
          count_d           = count_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      queue_enable_q   <= 1'b1;
      modifier_codes_q <= '0;
      count_q          <= '0;
    end else begin
      count_q <= count_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          kst_pkg::CfgQueueEnable: begin
            queue_enable_q <= cfg_wdata_i[0];
          end
          kst_pkg::CfgModifierCodes: begin
            modifier_codes_q <= cfg_wdata_i;
          end
          default: begin
          end
        endcase
      end
    end
  end

  kst_modtrack u_modtrack (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .evt_i   (evt),
    .codes_i (modifier_codes_q),
    .reload_i(reload),
    .status_o(mod_status)
  );

  kst_outbuf u_outbuf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (accept),
    .res_i      (res),
    .out_stall_i(out_stall_i),
    .out_valid_o(out_valid_o),
    .res_o      (res_out),
    .skid_full_o(skid_full)
  );

  assign in_stall_o      = skid_full || mod_status.busy;
  assign stored_o        = res_out.stored;
  assign dropped_o       = res_out.dropped;
  assign slot_index_o    = res_out.slot_index;
  assign scancode_out_o  = res_out.scancode;
  assign modifier_mask_o = res_out.modifier_mask;

`ifndef SYNTHESIS
  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(BUFFER_DEPTH))
    else $error("Entry count exceeds the buffer depth.");

  a_busy_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mod_status.busy |-> in_stall_o)
    else $error("Input not stalled during modifier reload.");

  a_stored_xor_dropped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(stored_o && dropped_o))
    else $error("Result word both stored and dropped.");

  a_unstored_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !stored_o) |->
      (slot_index_o == '0 && scancode_out_o == '0 && modifier_mask_o == '0))
    else $error("Unstored result word carries payload.");

  a_count_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !action_i && queue_enable_q && !full) |=>
      (count_q == $past(count_q) + 1'b1))
    else $error("Entry count did not advance on a stored word.");
`endif

endmodule
